// ===== design/base64_stream_codec_unit_assert.svh =====
// assertion macros for the base64 stream codec
// used by the top level only, no other dependencies
`ifndef BASE64_STREAM_CODEC_UNIT_ASSERT_SVH
`define BASE64_STREAM_CODEC_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64SC_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("b64sc assertion failed");

// next-cycle implication, checked outside reset
`define B64SC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("b64sc assertion failed");

`endif

// ===== design/b64sc_pkg.sv =====
// shared types, character constants and alphabet functions of the base64 codec
// no dependencies
package b64sc_pkg;

  localparam int unsigned MaxResults = 4;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_e;

  typedef enum logic {
    RegMode = 1'b0
  } reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       run_last;
    logic       stream_end;
    logic       error;
  } out_item_t;

  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  group_count;
    logic        padding_seen;
    logic        error_latched;
  } state_t;

  // results of one item and the stream state it leaves
  typedef struct packed {
    out_item_t [MaxResults-1:0] res;
    logic [2:0]                 n;
    state_t                     nxt;
  } step_t;

  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] c;
    if (s < 6'd26) begin
      c = CharUpperA + 8'(s);
    end else if (s < 6'd52) begin
      c = CharLowerA + 8'(s) - 8'd26;
    end else if (s < 6'd62) begin
      c = CharZero + 8'(s) - 8'd52;
    end else if (s == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  // {valid, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r = {1'b1, 6'(c - CharUpperA)};
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      r = {1'b1, 6'(c - CharLowerA + 8'd26)};
    end else if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, 6'(c - CharZero + 8'd52)};
    end else if (c == CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      r = {1'b1, 6'd63};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic out_item_t data_item(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.has_data = 1'b1;
    return r;
  endfunction

  function automatic out_item_t error_item();
    out_item_t r;
    r = '0;
    r.error = 1'b1;
    return r;
  endfunction

endpackage

// ===== design/b64sc_encode.sv =====
// encode step: one raw byte into the group, four characters per full or flushed group
// depends on b64sc_pkg
module b64sc_encode
  import b64sc_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  input  state_t     state_i,
  output step_t      step_o
);

  logic [23:0] gb;
  logic [23:0] v;
  logic [2:0]  cnt;
  logic        full;
  logic        short2;

  always_comb begin
    gb     = {state_i.group_bits[15:0], data_byte_i};
    cnt    = {1'b0, state_i.group_count} + 3'd1;
    full   = (cnt >= 3'd3);
    short2 = (cnt == 3'd1);
    v      = gb;
    step_o = '0;
    step_o.nxt = state_i;
    if (full) begin
      v = gb;
    end else if (short2) begin
      v = {data_byte_i, 16'h0000};
    end else begin
      v = {state_i.group_bits[7:0], data_byte_i, 8'h00};
    end
    if (full || last_i) begin
      step_o.res[0] = data_item(b64_char(v[23:18]));
      step_o.res[1] = data_item(b64_char(v[17:12]));
      step_o.res[2] = data_item(short2 && !full ? CharPad : b64_char(v[11:6]));
      step_o.res[3] = data_item(full ? b64_char(v[5:0]) : CharPad);
      step_o.n      = 3'd4;
      step_o.nxt.group_bits  = '0;
      step_o.nxt.group_count = '0;
    end else begin
      step_o.nxt.group_bits  = gb;
      step_o.nxt.group_count = cnt[1:0];
    end
  end

endmodule

// ===== design/b64sc_decode.sv =====
// decode step: one character to six bits, bytes per full or flushed group
// depends on b64sc_pkg
module b64sc_decode
  import b64sc_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  input  state_t     state_i,
  output step_t      step_o
);

  logic [6:0]  sx;
  logic [23:0] gb_new;
  logic [2:0]  cnt_new;

  always_comb begin
    sx      = b64_sextet(data_byte_i);
    gb_new  = {state_i.group_bits[17:0], sx[5:0]};
    cnt_new = {1'b0, state_i.group_count} + 3'd1;
    step_o  = '0;
    step_o.nxt = state_i;
    if (state_i.error_latched) begin
      // dropping until the stream ends
    end else if (data_byte_i == CharPad) begin
      if (!state_i.padding_seen) begin
        case (state_i.group_count)
          2'd1: begin
            step_o.res[0] = error_item();
            step_o.n      = 3'd1;
            step_o.nxt.error_latched = 1'b1;
          end
          2'd2: begin
            step_o.res[0] = data_item(state_i.group_bits[11:4]);
            step_o.n      = 3'd1;
          end
          2'd3: begin
            step_o.res[0] = data_item(state_i.group_bits[17:10]);
            step_o.res[1] = data_item(state_i.group_bits[9:2]);
            step_o.n      = 3'd2;
          end
          default: ;
        endcase
        if (state_i.group_count != 2'd1) begin
          step_o.nxt.group_bits   = '0;
          step_o.nxt.group_count  = '0;
          step_o.nxt.padding_seen = 1'b1;
        end
      end
    end else if (!sx[6] || state_i.padding_seen) begin
      step_o.res[0] = error_item();
      step_o.n      = 3'd1;
      step_o.nxt.error_latched = 1'b1;
    end else if (cnt_new == 3'd4) begin
      step_o.res[0] = data_item(gb_new[23:16]);
      step_o.res[1] = data_item(gb_new[15:8]);
      step_o.res[2] = data_item(gb_new[7:0]);
      step_o.n      = 3'd3;
      step_o.nxt.group_bits  = '0;
      step_o.nxt.group_count = '0;
    end else begin
      step_o.nxt.group_bits  = gb_new;
      step_o.nxt.group_count = cnt_new[1:0];
      if (last_i) begin
        case (cnt_new[1:0])
          2'd1: begin
            step_o.res[0] = error_item();
            step_o.n      = 3'd1;
            step_o.nxt.error_latched = 1'b1;
          end
          2'd2: begin
            step_o.res[0] = data_item(gb_new[11:4]);
            step_o.n      = 3'd1;
          end
          2'd3: begin
            step_o.res[0] = data_item(gb_new[17:10]);
            step_o.res[1] = data_item(gb_new[9:2]);
            step_o.n      = 3'd2;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/b64sc_res_buf.sv =====
// result register: holds up to four results of one item and emits one per cycle unless the output stalls
// depends on b64sc_pkg
module b64sc_res_buf
  import b64sc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  out_item_t [MaxResults-1:0] res_i,
  input  logic [2:0]                 n_i,
  output logic                       free_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output out_item_t                  out_item_o
);

  out_item_t [MaxResults-1:0] res_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;
  logic       last_slot;

  assign out_valid_o = (cnt_q != 3'd0);
  assign out_item_o  = res_q[idx_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign last_slot   = (idx_q == 2'(cnt_q - 3'd1));
  assign free_o      = !out_valid_o || (pop && last_slot);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = n_i;
      idx_d = '0;
    end else if (pop) begin
      if (last_slot) begin
        cnt_d = '0;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== design/base64_stream_codec_unit.sv =====
// top level of the streaming base64 codec: input register, step logic, result register
// depends on b64sc_pkg, b64sc_encode, b64sc_decode, b64sc_res_buf and the assert header
//
// usage
//   mode register at byte address 0 (bit 0): 0 encodes raw bytes to base64 text,
//   1 decodes text to bytes; any write restarts the stream, write only while idle
//   input channel: in_valid_i / in_stall_o / in_item_i carry one byte or character
//   per item, last_in closes the stream
//   output channel: out_valid_o / out_stall_i / out_item_o, zero to four results
//   per item, run_last marks the last result of an item, stream_end the last of
//   the stream
// timing
//   results load into the result register once the item in the input register is
//   worked on, and are offered from then on, one per cycle unless the output stalls;
//   an item holds the result register until its last result is taken, the next item
//   waiting in the input register: encode 4 results per 3 bytes, decode 3 per 4 characters
// reset and stall
//   reset clears mode (encode), stream state and both registers' valid flags
//   a stall on the output holds the current result; the input register then
//   fills and in_stall_o rises until the result register frees up
module base64_stream_codec_unit
  import b64sc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "base64_stream_codec_unit_assert.svh"

  // input register
  in_item_t in_q;
  logic     in_vld_q, in_vld_d;
  logic     in_accept;

  // stream state and mode
  state_t   state_q, state_d;
  mode_e    mode_q, mode_d;
  logic     cfg_write;

  // step logic
  step_t    enc_step, dec_step, fin_step;
  logic     buf_free;
  logic     process;

  // configuration port, single register at word 0
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (reg_e'(paddr[2]) == RegMode);
  assign prdata    = (reg_e'(paddr[2]) == RegMode) ? {31'h0, mode_q} : 32'h0;

  // an item is worked on once the result register can take its results
  assign process    = in_vld_q && buf_free;
  assign in_stall_o = in_vld_q && !process;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept || (in_vld_q && !process);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  b64sc_encode u_encode (
    .data_byte_i (in_q.data_byte),
    .last_i      (in_q.last_in),
    .state_i     (state_q),
    .step_o      (enc_step)
  );

  b64sc_decode u_decode (
    .data_byte_i (in_q.data_byte),
    .last_i      (in_q.last_in),
    .state_i     (state_q),
    .step_o      (dec_step)
  );

  // end-of-item and end-of-stream marking
  always_comb begin
    fin_step = (mode_q == ModeDecode) ? dec_step : enc_step;
    if (in_q.last_in) begin
      // a quiet last item still closes the stream with one empty result
      if (fin_step.n == 3'd0) begin
        fin_step.res[0] = '0;
        fin_step.n      = 3'd1;
      end
      fin_step.nxt = '0;
    end
    for (int i = 0; i < MaxResults; i++) begin
      if (fin_step.n != 3'd0 && 3'(i) == fin_step.n - 3'd1) begin
        fin_step.res[i].run_last   = 1'b1;
        fin_step.res[i].stream_end = in_q.last_in;
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    state_d = state_q;
    if (cfg_write) begin
      mode_d  = mode_e'(pwdata[0]);
      state_d = '0;
    end else if (process) begin
      state_d = fin_step.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeEncode;
      state_q <= '0;
    end else begin
      mode_q  <= mode_d;
      state_q <= state_d;
    end
  end

  b64sc_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (process),
    .res_i       (fin_step.res),
    .n_i         (fin_step.n),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // the last item of a stream leaves no state behind
  `B64SC_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, process && in_q.last_in && !cfg_write,
                     state_q == '0)
  // an item with results puts one on the output next cycle
  `B64SC_ASSERT_NEXT(a_results_shown, clk_i, rst_ni, process && fin_step.n != 3'd0,
                     out_valid_o)
  // an item waiting on the result register stays put
  `B64SC_ASSERT_NEXT(a_item_held, clk_i, rst_ni, in_vld_q && !process,
                     in_vld_q && $stable(in_q))
  // the end of a stream is always the end of its item
  `B64SC_ASSERT_NOW(a_end_is_item_end, clk_i, rst_ni, out_valid_o && out_item_o.stream_end,
                    out_item_o.run_last)

endmodule
